// ----- rtl/two_level_queue_schedule_times_core_macros.svh -----
// Assertion macros for the two-level queue schedule times core.
// Used by the port checker; no other dependencies.
`ifndef TWO_LEVEL_QUEUE_SCHEDULE_TIMES_CORE_MACROS_SVH
`define TWO_LEVEL_QUEUE_SCHEDULE_TIMES_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define TLQ_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("tlq check failed");

// Next-cycle implication checked outside reset
`define TLQ_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("tlq check failed");

`endif

// ----- rtl/tlqs_pkg.sv -----
// Shared types and constants for the two-level queue schedule times core.
// No dependencies.
package tlqs_pkg;
  localparam int unsigned TimeW = 23;
  localparam int unsigned FieldW = 16;

  // One record handed from the loader to the scheduler
  typedef struct packed {
    logic [FieldW-1:0] proc_id;
    logic [FieldW-1:0] arrival;
    logic [FieldW-1:0] burst;
    logic              is_user;
    logic              final_record;
  } rec_t;
endpackage

// ----- rtl/two_level_queue_schedule_times_core.sv -----
// Two-level queue schedule times: loads records, then schedules every system process
// before any user process, non-preemptively, and returns start, completion, turnaround
// and waiting per record in load order. A record transfers at an edge with start high
// and busy low; it passes a two-entry queue and is then stored once the back end is
// loading. On a final record the scheduler places records by repeated minimum search
// over the N stored records: each placement is a scan over the stored records and a
// timing step, and one more scan is spent when any user records are present, before
// the results are emitted. Busy rises once two records wait behind a schedule pass.
// Results appear one per strobe (done) and cannot be held off; last_result marks the
// last stored record. Records past MAX_PROCS are dropped, but a dropped final record
// still starts the schedule of the stored set.
module two_level_queue_schedule_times_core import tlqs_pkg::*; #(
  parameter int unsigned MAX_PROCS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [15:0]       proc_id,
  input  logic [15:0]       arrival,
  input  logic [15:0]       burst,
  input  logic              is_user,
  input  logic              final_record,
  output logic              done,
  output logic [15:0]       out_id,
  output logic [22:0]       start_time,
  output logic [22:0]       completion,
  output logic [22:0]       turnaround,
  output logic [22:0]       waiting,
  output logic              last_result
);
  rec_t in_rec, head;
  logic full, avail, pop;

  assign in_rec = '{proc_id: proc_id, arrival: arrival, burst: burst,
                    is_user: is_user, final_record: final_record};
  assign busy = full;

  // Queue records between intake and scheduler
  tlqs_front u_front (
    .clk(clk), .rst(rst), .push(start && !full), .push_rec(in_rec),
    .full(full), .pop(pop), .avail(avail), .head(head)
  );

  // Store, order, time and emit
  tlqs_back #(.MaxProcs(MAX_PROCS)) u_back (
    .clk(clk), .rst(rst), .avail(avail), .head(head), .pop(pop),
    .done(done), .out_id(out_id), .start_time(start_time),
    .completion(completion), .turnaround(turnaround), .waiting(waiting),
    .last_result(last_result)
  );
endmodule

// ----- rtl/tlqs_front.sv -----
// Front end: accepts records into a two-entry queue toward the scheduler.
// Depends on tlqs_pkg.
module tlqs_front import tlqs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t push_rec,
  output logic full,
  input  logic pop,
  output logic avail,
  output rec_t head
);
  rec_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head = slots[rd_ptr];

  // Write, advance pointers and track fill
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_rec;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- rtl/tlqs_back.sv -----
// Back end: stores records, builds the run order, times it, emits results.
// Depends on tlqs_pkg.
module tlqs_back import tlqs_pkg::*; #(
  parameter int unsigned MaxProcs = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              avail,
  input  rec_t              head,
  output logic              pop,
  output logic              done,
  output logic [FieldW-1:0] out_id,
  output logic [TimeW-1:0]  start_time,
  output logic [TimeW-1:0]  completion,
  output logic [TimeW-1:0]  turnaround,
  output logic [TimeW-1:0]  waiting,
  output logic              last_result
);
  localparam int unsigned IdxW = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int unsigned CntW = $clog2(MaxProcs + 1);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_RUNW = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_OUTW = 3'd5;

  // Record memories and per-record start times
  logic [FieldW-1:0] id_mem  [MaxProcs];
  logic [FieldW-1:0] arr_mem [MaxProcs];
  logic [FieldW-1:0] bur_mem [MaxProcs];
  logic              cls_mem [MaxProcs];
  logic [TimeW-1:0]  st_mem  [MaxProcs];

  logic [2:0]       state;
  logic [CntW-1:0]  loaded;
  logic [CntW-1:0]  idx;
  logic             pass;
  logic             have_best;
  logic [FieldW-1:0] best_arr;
  logic [IdxW-1:0]  best_idx;
  logic [CntW-1:0]  placed;
  logic [MaxProcs-1:0] taken;
  logic [TimeW-1:0] clock_now;
  logic [FieldW-1:0] rd_id, rd_arr, rd_bur;
  logic             rd_cls;
  logic [TimeW-1:0] rd_st;
  logic [IdxW-1:0]  ridx;
  logic [IdxW-1:0]  sidx;
  logic [TimeW-1:0] run_start;

  assign pop = avail && (state == S_LOAD);
  assign sidx = idx[IdxW-1:0];

  // Read address: scanning index, chosen record, or output index
  always_comb begin
    case (state)
      S_RUN, S_RUNW: ridx = best_idx;
      default:       ridx = sidx;
    endcase
  end

  // Registered memory reads
  always_ff @(posedge clk) begin
    rd_id  <= id_mem[ridx];
    rd_arr <= arr_mem[ridx];
    rd_bur <= bur_mem[ridx];
    rd_cls <= cls_mem[ridx];
    rd_st  <= st_mem[ridx];
  end

  // Store incoming records while room remains
  always_ff @(posedge clk) begin
    if (pop && (loaded < CntW'(MaxProcs))) begin
      id_mem[loaded[IdxW-1:0]]  <= head.proc_id;
      arr_mem[loaded[IdxW-1:0]] <= head.arrival;
      bur_mem[loaded[IdxW-1:0]] <= head.burst;
      cls_mem[loaded[IdxW-1:0]] <= head.is_user;
    end
    if (state == S_RUNW) st_mem[best_idx] <= run_start;
  end

  assign run_start = (clock_now < TimeW'(rd_arr)) ? TimeW'(rd_arr) : clock_now;

  // Load control, then selection sort by repeated minimum search (strict compare keeps load order), then output
  always_ff @(posedge clk) begin
    done <= 1'b0;
    out_id <= rd_id;
    start_time <= rd_st;
    completion <= rd_st + TimeW'(rd_bur);
    turnaround <= rd_st + TimeW'(rd_bur) - TimeW'(rd_arr);
    waiting <= rd_st - TimeW'(rd_arr);
    last_result <= (idx == loaded);
    if (rst) begin
      state <= S_LOAD;
      loaded <= '0;
      clock_now <= '0;
      idx <= '0;
      pass <= 1'b0;
      have_best <= 1'b0;
      placed <= '0;
      taken <= '0;
      best_idx <= '0;
      best_arr <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (pop) begin
            if (loaded < CntW'(MaxProcs)) loaded <= loaded + 1'b1;
            if (head.final_record) begin
              state <= S_SCAN;
              idx <= '0;
              pass <= 1'b0;
              have_best <= 1'b0;
              placed <= '0;
              taken <= '0;
              clock_now <= '0;
            end
          end
        end
        S_SCAN: begin
          // Data for idx-1 is in the read registers once idx > 0
          if (idx != '0) begin
            if (!taken[IdxW'(idx - 1'b1)] && (rd_cls == pass) &&
                (!have_best || rd_arr < best_arr)) begin
              have_best <= 1'b1;
              best_arr <= rd_arr;
              best_idx <= IdxW'(idx - 1'b1);
            end
          end
          if (idx == loaded) begin
            idx <= '0;
            if (have_best || (idx != '0 && !taken[IdxW'(idx - 1'b1)] &&
                (rd_cls == pass) && (!have_best || rd_arr < best_arr))) begin
              if (!(have_best) ) best_idx <= IdxW'(idx - 1'b1);
              state <= S_RUN;
            end else if (!pass) begin
              pass <= 1'b1;
            end else begin
              state <= S_OUT;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_RUN: state <= S_RUNW;
        S_RUNW: begin
          // Start at max(clock, arrival), then advance by burst
          clock_now <= run_start + TimeW'(rd_bur);
          taken[best_idx] <= 1'b1;
          have_best <= 1'b0;
          placed <= placed + 1'b1;
          state <= (placed + 1'b1 == loaded) ? S_OUT : S_SCAN;
          idx <= '0;
        end
        S_OUT: begin
          if (loaded == '0) begin
            state <= S_LOAD;
          end else begin
            idx <= idx + 1'b1;
            state <= S_OUTW;
          end
        end
        S_OUTW: begin
          done <= 1'b1;
          if (idx == loaded) begin
            state <= S_LOAD;
            loaded <= '0;
            idx <= '0;
          end else begin
            state <= S_OUT;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

// ----- rtl/tlqs_checker.sv -----
// Port-level checker for the schedule times core, bound to the top level.
// Depends on two_level_queue_schedule_times_core_macros.svh.
`include "two_level_queue_schedule_times_core_macros.svh"
module tlqs_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic [22:0] start_time,
  input logic [22:0] completion,
  input logic [22:0] turnaround,
  input logic [22:0] waiting
);
  `TLQ_ASSERT_IMP(a_tat, clk, rst, done, turnaround - waiting == completion - start_time)
  `TLQ_ASSERT_NXT(a_no_back, clk, rst, done, !done)
  `TLQ_ASSERT_IMP(a_wait_le, clk, rst, done, waiting <= start_time)
  `TLQ_ASSERT_IMP(a_busy_known, clk, rst, 1'b1, !$isunknown(busy))
endmodule

bind two_level_queue_schedule_times_core tlqs_checker u_chk (
  .clk(clk), .rst(rst), .busy(busy), .done(done),
  .start_time(start_time), .completion(completion),
  .turnaround(turnaround), .waiting(waiting)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the two-level queue schedule times core.
// Depends on tlqs_pkg and two_level_queue_schedule_times_core.
`timescale 1ns / 100ps

module tb_top import tlqs_pkg::*;;

  localparam int Depth = 64;
  localparam int CycleLimit = 400000;

  typedef struct {
    rec_t rec;
    bit   drain_first;
  } job_t;

  typedef struct {
    logic [15:0] id;
    logic [22:0] st;
    logic [22:0] ct;
    logic [22:0] tat;
    logic [22:0] wt;
    logic        last;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [15:0] proc_id = '0;
  logic [15:0] arrival = '0;
  logic [15:0] burst = '0;
  logic is_user = 1'b0;
  logic final_record = 1'b0;
  logic busy, done, last_result;
  logic [15:0] out_id;
  logic [22:0] start_time, completion, turnaround, waiting;

  job_t       pending_jobs[$];
  sched_res_t expected_times[$];
  int  fail_count = 0;
  int  cycle_count = 0;
  int  sent_count = 0;

  // Predictor copy of the record store
  logic [15:0] p_id[Depth];
  logic [15:0] p_arr[Depth];
  logic [15:0] p_bur[Depth];
  logic        p_cls[Depth];
  int          p_count = 0;

  two_level_queue_schedule_times_core dut (
    .clk, .rst, .start, .busy, .proc_id, .arrival, .burst, .is_user,
    .final_record, .done, .out_id, .start_time, .completion, .turnaround,
    .waiting, .last_result
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Store one record and, on the final one, schedule the set
  task automatic schedule_record(input rec_t r);
    int order[Depth];
    int start_at[Depth];
    int fill, base, pos, p, k;
    logic [22:0] now;
    sched_res_t res;
    if (p_count < Depth) begin
      p_id[p_count] = r.proc_id;
      p_arr[p_count] = r.arrival;
      p_bur[p_count] = r.burst;
      p_cls[p_count] = r.is_user;
      p_count++;
    end
    if (!r.final_record) return;
    fill = 0;
    // Build system queue then user queue, stable by arrival
    for (int cls = 0; cls < 2; cls++) begin
      base = fill;
      for (int i = 0; i < p_count; i++) begin
        if (p_cls[i] != cls) continue;
        pos = fill;
        while (pos > base && p_arr[order[pos-1]] > p_arr[i]) begin
          order[pos] = order[pos-1];
          pos--;
        end
        order[pos] = i;
        fill++;
      end
    end
    // Run in order, jumping over idle time
    now = '0;
    for (k = 0; k < fill; k++) begin
      p = order[k];
      if (now < 23'(p_arr[p])) now = 23'(p_arr[p]);
      start_at[p] = now;
      now = now + 23'(p_bur[p]);
    end
    for (int i = 0; i < p_count; i++) begin
      res.id = p_id[i];
      res.st = 23'(start_at[i]);
      res.ct = res.st + 23'(p_bur[i]);
      res.tat = res.ct - 23'(p_arr[i]);
      res.wt = res.st - 23'(p_arr[i]);
      res.last = (i + 1 == p_count);
      expected_times.push_back(res);
    end
    p_count = 0;
  endtask

  function automatic rec_t make_rec(input logic [15:0] id, input logic [15:0] arr,
                                    input logic [15:0] bur, input logic usr,
                                    input logic fin);
    rec_t r;
    r.proc_id = id;
    r.arrival = arr;
    r.burst = bur;
    r.is_user = usr;
    r.final_record = fin;
    return r;
  endfunction

  task automatic add_job(input rec_t r, input bit drain = 1'b0);
    job_t j;
    j.rec = r;
    j.drain_first = drain;
    pending_jobs.push_back(j);
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // Driver: hand the front job to the block, idling at random
  always @(posedge clk) begin
    bit calm;
    bit hold;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        schedule_record(pending_jobs[0].rec);
        pending_jobs.pop_front();
        sent_count++;
      end
      calm = (sent_count >= 20 && sent_count < 60);
      hold = (pending_jobs.size() == 0) ||
             (pending_jobs[0].drain_first && expected_times.size() != 0) ||
             (!calm && $urandom_range(0, 99) < 35);
      if (!hold) begin
        start <= 1'b1;
        proc_id <= pending_jobs[0].rec.proc_id;
        arrival <= pending_jobs[0].rec.arrival;
        burst <= pending_jobs[0].rec.burst;
        is_user <= pending_jobs[0].rec.is_user;
        final_record <= pending_jobs[0].rec.final_record;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    sched_res_t e;
    if (!rst && done) begin
      if (expected_times.size() == 0) begin
        $error("unexpected result: out_id %0h", out_id);
        fail_count++;
      end else begin
        e = expected_times.pop_front();
        if (out_id !== e.id) begin
          $error("out_id: expected %0h actual %0h", e.id, out_id);
          fail_count++;
        end
        if (start_time !== e.st) begin
          $error("start_time: expected %0d actual %0d", e.st, start_time);
          fail_count++;
        end
        if (completion !== e.ct) begin
          $error("completion: expected %0d actual %0d", e.ct, completion);
          fail_count++;
        end
        if (turnaround !== e.tat) begin
          $error("turnaround: expected %0d actual %0d", e.tat, turnaround);
          fail_count++;
        end
        if (waiting !== e.wt) begin
          $error("waiting: expected %0d actual %0d", e.wt, waiting);
          fail_count++;
        end
        if (last_result !== e.last) begin
          $error("last_result: expected %0b actual %0b", e.last, last_result);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("two_level_queue_schedule_times_core regression: fail");
      $finish;
    end
  end

  initial begin
    int n;
    // Single system record, all zero
    add_job(make_rec(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1));
    // Single user record at the field maxima
    add_job(make_rec(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    // User loaded first and arriving early still runs after system
    add_job(make_rec(16'h0001, 16'h0000, 16'h0005, 1'b1, 1'b0));
    add_job(make_rec(16'h0002, 16'h0009, 16'h0003, 1'b0, 1'b0));
    add_job(make_rec(16'h0003, 16'h0002, 16'h0004, 1'b0, 1'b1));
    // Arrival ties keep load order; zero bursts; idle gap jump
    add_job(make_rec(16'h0010, 16'h0007, 16'h0002, 1'b0, 1'b0));
    add_job(make_rec(16'h0011, 16'h0007, 16'h0000, 1'b0, 1'b0));
    add_job(make_rec(16'h0012, 16'h0007, 16'h0001, 1'b0, 1'b0));
    add_job(make_rec(16'h0013, 16'h8000, 16'h0010, 1'b1, 1'b0));
    add_job(make_rec(16'h0014, 16'h8000, 16'h0010, 1'b1, 1'b1));
    // Full store, then two more records: the final one is dropped
    for (int i = 0; i < Depth + 2; i++)
      add_job(make_rec(16'($urandom), 16'hFFFF, 16'hFFFF, 1'($urandom),
                       i == Depth + 1), i == 0);
    // Random sets, mostly small, some with many ties
    n = 0;
    while (n < 24) begin
      int sz;
      bit ties;
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      ties = $urandom_range(0, 2) == 0;
      for (int i = 0; i < sz; i++)
        add_job(make_rec(16'($urandom),
                         ties ? 16'($urandom_range(0, 3)) : rand_field(),
                         rand_field(), 1'($urandom), i == sz - 1),
                i == 0 && $urandom_range(0, 4) == 0);
      n += sz;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (pending_jobs.size() == 0 && !start);
    wait (expected_times.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_times.size() == 0) begin
      $display("two_level_queue_schedule_times_core regression: pass");
    end else begin
      $display("two_level_queue_schedule_times_core regression: fail");
    end
    $finish;
  end
endmodule
